>>> design/tgt_pkg.sv
`default_nettype none
package tgt_pkg;

	localparam int NUM_MOTORS = 8;
	localparam int POS_W      = 32;

	// Motor table index width and the common working widths.
	localparam int MIDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
	localparam int MW     = (POS_W > 32) ? POS_W : 32;
	localparam int WW     = MW + 2;
	localparam int CNT_W  = $clog2(MW + 1);

	localparam logic signed [WW-1:0] POS_HI = WW'((longint'(1) << (POS_W - 1)) - 1);
	localparam logic signed [WW-1:0] POS_LO = -POS_HI - WW'(1);
	localparam logic signed [WW-1:0] ERR_HI = WW'(64'sd2147483647);
	localparam logic signed [WW-1:0] ERR_LO = -ERR_HI - WW'(1);

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_TARGET = 2'd1,
		OP_RESYNC = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_ACCEL  = 2'd0,
		REG_SPDMAX = 2'd1,
		REG_ERRMAX = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_SPD,
		ST_POS,
		ST_ERR,
		ST_OUT
	} state_t;

	// Saturates a working value to the stored position width.
	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WW-1:0] x);
		if (x > POS_HI) begin
			return POS_HI[POS_W-1:0];
		end else if (x < POS_LO) begin
			return POS_LO[POS_W-1:0];
		end else begin
			return x[POS_W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

>>> design/trapezoidal_ghost_trajectory.sv
`default_nettype none
// Trapezoidal ghost trajectory generator for up to eight motors, with a
// following-error check on every control tick.
// Items enter on the input channel (in_valid, in_stall) carrying op, motor,
// position and speed; each item yields exactly one result item on the output
// channel (out_valid, out_stall). The block works on one item at a time: in_stall
// is high from acceptance until the result item has been taken.
// For a set-target, resync or clear-fault item, or a tick for a motor out of
// range, the state goes from PREP straight to OUT, where out_valid rises. A
// tick item passes PREP, MUL, SPD, POS and ERR first; MUL waits on the two
// bit-serial multipliers that form 2*a*|d| and v*v for the braking test, one
// multiplier bit per cycle. With no stall, a new item is taken in the IDLE
// state that follows once the result has gone.
// When the receiver stalls, the result item is held in the output registers and
// no new item is taken until it has gone.
// Reset clears the motor tables, fault bits and configuration to their defaults
// and leaves the block idle and ready. Configuration writes (cfg_we, cfg_index,
// cfg_data) take effect at the clock edge and should be made while idle.
module trapezoidal_ghost_trajectory (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [30:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         op,
	input  wire logic [2:0]         motor,
	input  wire logic signed [31:0] position,
	input  wire logic signed [31:0] speed,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              motor_out,
	output logic signed [31:0]      ghost_position,
	output logic signed [31:0]      ghost_speed,
	output logic signed [31:0]      position_error,
	output logic                    over_limit,
	output logic                    any_fault
);

	localparam int NM = tgt_pkg::NUM_MOTORS;
	localparam int PW = tgt_pkg::POS_W;
	localparam int MW = tgt_pkg::MW;
	localparam int WW = tgt_pkg::WW;

	// Configuration registers.
	logic [30:0] accel_q;
	logic [30:0] smax_q;
	logic [30:0] emax_q;

	// Per-motor state.
	logic signed [PW-1:0] target_q [NM];
	logic signed [PW-1:0] gpos_q   [NM];
	logic signed [31:0]   gspd_q   [NM];
	logic [NM-1:0]        mfault_q;
	logic                 gfault_q;

	tgt_pkg::state_t state_q, state_d;

	// The item being worked on.
	tgt_pkg::op_t             op_q;
	logic [2:0]               motor_q;
	logic signed [31:0]       pos_q;
	logic signed [31:0]       spd_q;
	logic [tgt_pkg::MIDX_W-1:0] idx;
	logic                     in_range;

	// Tick working registers.
	logic                 dpos_q;
	logic                 far_q;
	logic signed [31:0]   v_q;
	logic signed [PW-1:0] gp_q;
	logic signed [31:0]   nv_q;
	logic signed [PW-1:0] gpn_q;

	// Result registers.
	logic signed [31:0] res_gp_q;
	logic signed [31:0] res_gs_q;
	logic signed [31:0] res_err_q;
	logic               res_over_q;
	logic               res_any_q;

	logic              mul_start;
	logic              done_a, done_b;
	logic [2*MW-1:0]   prod_a, prod_b;

	logic signed [PW-1:0] tgt_rd, gp_rd;
	logic signed [31:0]   v_rd;
	logic signed [WW-1:0] d_c, ad_c;
	logic signed [32:0]   vx_c, av_c;

	logic signed [33:0] vs_c, as_c, sm_c, up_c, dn_c, nvr_c, nvc_c;
	logic signed [WW-1:0] psum_c, e_c, e32_c;
	logic signed [32:0]   ae_c;
	logic                 over_c;

	assign idx      = tgt_pkg::MIDX_W'(motor_q);
	assign in_range = (32'(motor_q) < NM);

	assign tgt_rd = target_q[idx];
	assign gp_rd  = gpos_q[idx];
	assign v_rd   = gspd_q[idx];

	// Distance to target and speed magnitude feed the multipliers.
	assign d_c  = WW'(tgt_rd) - WW'(gp_rd);
	assign ad_c = (d_c < 0) ? -d_c : d_c;
	assign vx_c = 33'(v_rd);
	assign av_c = (vx_c < 0) ? -vx_c : vx_c;

	assign mul_start = (state_q == tgt_pkg::ST_PREP) && (op_q == tgt_pkg::OP_TICK) && in_range;

	tgt_smul u_mul_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (MW'({accel_q, 1'b0})),
		.mplier  (MW'(ad_c[MW-1:0])),
		.done    (done_a),
		.product (prod_a)
	);

	tgt_smul u_mul_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (MW'(av_c[31:0])),
		.mplier  (MW'(av_c[31:0])),
		.done    (done_b),
		.product (prod_b)
	);

	// New speed: accelerate toward the target while far, otherwise brake to zero; clamped to the speed limit.
	assign vs_c = 34'(v_q);
	assign as_c = $signed({3'b000, accel_q});
	assign sm_c = $signed({3'b000, smax_q});
	assign up_c = vs_c + as_c;
	assign dn_c = vs_c - as_c;

	always_comb begin
		if (dpos_q) begin
			nvr_c = far_q ? up_c : ((dn_c < 0) ? 34'sd0 : dn_c);
		end else begin
			nvr_c = far_q ? dn_c : ((up_c > 0) ? 34'sd0 : up_c);
		end
		if (nvr_c > sm_c) begin
			nvc_c = sm_c;
		end else if (nvr_c < -sm_c) begin
			nvc_c = -sm_c;
		end else begin
			nvc_c = nvr_c;
		end
	end

	assign psum_c = WW'(gp_q) + WW'(nv_q);

	// Following error, saturated to 32 bits.
	assign e_c    = WW'(gpn_q) - WW'(pos_q);
	assign e32_c  = (e_c > tgt_pkg::ERR_HI) ? tgt_pkg::ERR_HI :
	                (e_c < tgt_pkg::ERR_LO) ? tgt_pkg::ERR_LO : e_c;
	assign ae_c   = (e32_c < 0) ? -33'(e32_c) : 33'(e32_c);
	assign over_c = $unsigned(ae_c) > 33'(emax_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tgt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			tgt_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = tgt_pkg::ST_PREP;
				end
			end
			tgt_pkg::ST_PREP: begin
				state_d = mul_start ? tgt_pkg::ST_MUL : tgt_pkg::ST_OUT;
			end
			tgt_pkg::ST_MUL: begin
				if (done_a) begin
					state_d = tgt_pkg::ST_SPD;
				end
			end
			tgt_pkg::ST_SPD: state_d = tgt_pkg::ST_POS;
			tgt_pkg::ST_POS: state_d = tgt_pkg::ST_ERR;
			tgt_pkg::ST_ERR: state_d = tgt_pkg::ST_OUT;
			tgt_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_d = tgt_pkg::ST_IDLE;
				end
			end
			default: state_d = tgt_pkg::ST_IDLE;
		endcase
	end

	// Configuration, motor tables and fault flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q  <= 31'd655;
			smax_q   <= 31'd65536;
			emax_q   <= 31'd655360;
			mfault_q <= '0;
			gfault_q <= 1'b0;
			for (int i = 0; i < NM; i++) begin
				target_q[i] <= '0;
				gpos_q[i]   <= '0;
				gspd_q[i]   <= '0;
			end
		end else begin
			if (cfg_we) begin
				priority case (cfg_index)
					tgt_pkg::REG_ACCEL:  accel_q <= cfg_data;
					tgt_pkg::REG_SPDMAX: smax_q  <= cfg_data;
					tgt_pkg::REG_ERRMAX: emax_q  <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == tgt_pkg::ST_PREP) begin
				if (op_q == tgt_pkg::OP_CLEAR) begin
					gfault_q <= 1'b0;
				end
				if (in_range && op_q == tgt_pkg::OP_TARGET) begin
					target_q[idx] <= tgt_pkg::sat_pos(WW'(pos_q));
				end
				if (in_range && op_q == tgt_pkg::OP_RESYNC) begin
					gpos_q[idx] <= tgt_pkg::sat_pos(WW'(pos_q));
					gspd_q[idx] <= spd_q;
				end
			end
			if (state_q == tgt_pkg::ST_SPD) begin
				gspd_q[idx] <= nvc_c[31:0];
			end
			if (state_q == tgt_pkg::ST_POS) begin
				gpos_q[idx] <= tgt_pkg::sat_pos(psum_c);
			end
			if (state_q == tgt_pkg::ST_ERR && over_c) begin
				mfault_q[idx] <= 1'b1;
				gfault_q      <= 1'b1;
			end
		end
	end

	// Item and working registers.
	always_ff @(posedge clk) begin
		if (state_q == tgt_pkg::ST_IDLE && in_valid) begin
			op_q    <= tgt_pkg::op_t'(op);
			motor_q <= motor;
			pos_q   <= position;
			spd_q   <= speed;
		end
		if (state_q == tgt_pkg::ST_PREP) begin
			dpos_q     <= (d_c > 0);
			v_q        <= v_rd;
			gp_q       <= gp_rd;
			res_err_q  <= '0;
			res_over_q <= 1'b0;
			res_any_q  <= (op_q == tgt_pkg::OP_CLEAR) ? 1'b0 : gfault_q;
			if (!in_range) begin
				res_gp_q <= '0;
				res_gs_q <= '0;
			end else if (op_q == tgt_pkg::OP_RESYNC) begin
				res_gp_q <= 32'(tgt_pkg::sat_pos(WW'(pos_q)));
				res_gs_q <= spd_q;
			end else begin
				res_gp_q <= 32'(gp_rd);
				res_gs_q <= v_rd;
			end
		end
		if (state_q == tgt_pkg::ST_MUL && done_a) begin
			far_q <= (prod_a > prod_b);
		end
		if (state_q == tgt_pkg::ST_SPD) begin
			nv_q     <= nvc_c[31:0];
			res_gs_q <= nvc_c[31:0];
		end
		if (state_q == tgt_pkg::ST_POS) begin
			gpn_q    <= tgt_pkg::sat_pos(psum_c);
			res_gp_q <= 32'(tgt_pkg::sat_pos(psum_c));
		end
		if (state_q == tgt_pkg::ST_ERR) begin
			res_err_q  <= e32_c[31:0];
			res_over_q <= over_c;
			res_any_q  <= gfault_q | over_c;
		end
	end

	assign motor_out      = motor_q;
	assign ghost_position = res_gp_q;
	assign ghost_speed    = res_gs_q;
	assign position_error = res_err_q;
	assign over_limit     = res_over_q;
	assign any_fault      = res_any_q;

	// The two multipliers run in lock step.
	assert property (@(posedge clk) disable iff (!arst_n) done_a == done_b)
		else $error("multipliers out of step");

	// A flagged tick always leaves the global fault set.
	assert property (@(posedge clk) disable iff (!arst_n) out_valid && over_limit |-> any_fault)
		else $error("over_limit without any_fault");

	// A tick's new speed never exceeds the speed limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tgt_pkg::ST_POS |-> (34'(nv_q) <= sm_c) && (34'(nv_q) >= -sm_c))
		else $error("speed outside limit");

	// No result is shown in the cycle after an item is taken.
	assert property (@(posedge clk) disable iff (!arst_n) in_valid && !in_stall |=> !out_valid)
		else $error("result shown too early");

	// Multiplier completion only happens while waiting for it.
	assert property (@(posedge clk) disable iff (!arst_n) done_a |-> state_q == tgt_pkg::ST_MUL)
		else $error("stray multiplier completion");

endmodule
`default_nettype wire

>>> design/tgt_smul.sv
`default_nettype none
// Shift-and-add multiplier, one multiplier bit per cycle, LSB first.
module tgt_smul (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [tgt_pkg::MW-1:0]       mcand,
	input  wire logic [tgt_pkg::MW-1:0]       mplier,
	output logic                              done,
	output logic [2*tgt_pkg::MW-1:0]          product
);

	logic [tgt_pkg::CNT_W-1:0] cnt_q;
	logic                      done_q;
	logic [tgt_pkg::MW-1:0]    hi_q;
	logic [tgt_pkg::MW-1:0]    lo_q;
	logic [tgt_pkg::MW-1:0]    mcand_q;
	logic [tgt_pkg::MW:0]      sum;

	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= tgt_pkg::CNT_W'(tgt_pkg::MW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - tgt_pkg::CNT_W'(1);
				if (cnt_q == tgt_pkg::CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hi_q    <= '0;
			lo_q    <= mplier;
			mcand_q <= mcand;
		end else if (cnt_q != '0) begin
			hi_q <= sum[tgt_pkg::MW:1];
			lo_q <= {sum[0], lo_q[tgt_pkg::MW-1:1]};
		end
	end

	assign done    = done_q;
	assign product = {hi_q, lo_q};

endmodule
`default_nettype wire
